/* rtl/hsbrgb_pkg.sv */
// Package for the HSB to RGB LED frame sender.
// Holds the shared colour types, command and colour codes, and conversion constants.
// No dependencies.
package hsbrgb_pkg;

  // Input command codes
  localparam logic CMD_RGB = 1'b0;
  localparam logic CMD_HSB = 1'b1;

  // Colour codes on the result channel, in shift order per LED
  typedef enum logic [1:0] {
    COLOR_BLUE  = 2'd0,
    COLOR_GREEN = 2'd1,
    COLOR_RED   = 2'd2
  } color_t;

  // Three 8-bit channel levels of one colour
  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } chan_set_t;

  // Hue reduction: q = (hue * HUE_RECIP) >> HUE_RECIP_SHIFT is low by at most one
  localparam int unsigned HUE_MOD         = 765;
  localparam int unsigned HUE_RECIP       = 87724;
  localparam int unsigned HUE_RECIP_SHIFT = 26;

  // Sector bounds and offsets of the three-sector conversion
  localparam int unsigned SECTOR_1 = 255;
  localparam int unsigned SECTOR_2 = 510;
  localparam int signed   OFS_85   = 85;
  localparam int signed   OFS_170  = 170;
  localparam int signed   OFS_340  = 340;
  localparam int signed   OFS_425  = 425;
  localparam int signed   OFS_595  = 595;
  localparam int signed   OFS_680  = 680;

  // Channel base level and saturation limit
  localparam int signed   CHAN_BASE = 10880;
  localparam int unsigned SAT_MAX   = 128;

  // Widths of the result fields
  localparam int unsigned GRAY_W = 12;
  localparam int unsigned SLOT_W = 5;

endpackage

/* rtl/hsbrgb_in_if.sv */
// Input channel interface: one colour command per transfer.
// Valid/ready handshake; no package dependency.
interface hsbrgb_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [15:0] hue;
  logic [7:0]  saturation;
  logic [7:0]  brightness;

  modport source (output valid, command, red, green, blue, hue, saturation, brightness,
                  input ready);
  modport sink   (input valid, command, red, green, blue, hue, saturation, brightness,
                  output ready);
endinterface

/* rtl/hsbrgb_out_if.sv */
// Result channel interface: one grey-level word per transfer.
// Valid/ready handshake; no package dependency.
interface hsbrgb_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] gray_level;
  logic [4:0]  slot;
  logic [1:0]  color;
  logic        last;

  modport source (output valid, gray_level, slot, color, last, input ready);
  modport sink   (input valid, gray_level, slot, color, last, output ready);
endinterface

/* rtl/hsbrgb_front.sv */
// Front part: accepts colour commands and converts HSB to three 8-bit channels.
// Five-stage pipeline; uses hsbrgb_pkg and hsbrgb_in_if.
module hsbrgb_front (
  input  logic                  clk,
  input  logic                  rst,
  hsbrgb_in_if.sink             item,
  output logic                  q_valid,
  input  logic                  q_ready,
  output hsbrgb_pkg::chan_set_t q_data
);
  import hsbrgb_pkg::*;

  // Channel before brightness: max(CHAN_BASE - sat*off, 0) >> 7
  function automatic logic [7:0] chan_level(input logic [7:0] sat,
                                            input logic signed [10:0] off);
    logic signed [19:0] prod;
    logic signed [19:0] lvl;
    prod = $signed({1'b0, sat}) * off;
    lvl  = 20'(CHAN_BASE) - prod;
    if (lvl < 0) begin
      chan_level = 8'd0;
    end else begin
      chan_level = lvl[14:7];
    end
  endfunction

  logic en;

  // Stage 1 registers: captured command
  logic            v1, cmd1;
  chan_set_t       rgb1;
  logic [15:0]     hue1;
  logic [7:0]      sat1, bri1;
  // Stage 2: hue quotient estimate
  logic            v2, cmd2;
  chan_set_t       rgb2;
  logic [15:0]     hue2;
  logic [7:0]      sat2, bri2;
  logic [6:0]      quot2;
  // Stage 3: reduced hue
  logic            v3, cmd3;
  chan_set_t       rgb3;
  logic [9:0]      h3;
  logic [7:0]      sat3, bri3;
  // Stage 4: unscaled channels
  logic            v4, cmd4;
  chan_set_t       rgb4;
  chan_set_t       lvl4;
  logic [7:0]      bri4;
  // Stage 5: final channels
  logic            v5;
  chan_set_t       out5;

  logic [32:0]        quot_prod;
  logic [16:0]        rem_raw;
  logic [16:0]        rem_fix;
  logic signed [10:0] hs;
  logic signed [10:0] off_r, off_g, off_b;
  logic [16:0]        sc_r, sc_g, sc_b;

  // Advance the whole pipe unless the last stage is blocked by a full queue
  assign en         = !v5 || q_ready;
  assign item.ready = en;
  assign q_valid    = v5;
  assign q_data     = out5;

  // Quotient estimate and remainder correction
  assign quot_prod = 33'(hue1) * 33'(HUE_RECIP);
  assign rem_raw   = 17'(hue2) - 17'(quot2) * 17'(HUE_MOD);
  assign rem_fix   = (rem_raw >= 17'(HUE_MOD)) ? rem_raw - 17'(HUE_MOD) : rem_raw;

  // Sector offsets
  assign hs = $signed({1'b0, h3});
  always_comb begin
    if (h3 < 10'(SECTOR_1)) begin
      off_r = hs - 11'(OFS_170);
      off_g = 11'(OFS_85) - hs;
      off_b = 11'(OFS_85);
    end else if (h3 < 10'(SECTOR_2)) begin
      off_r = 11'(OFS_85);
      off_g = hs - 11'(OFS_425);
      off_b = 11'(OFS_340) - hs;
    end else begin
      off_r = 11'(OFS_595) - hs;
      off_g = 11'(OFS_85);
      off_b = hs - 11'(OFS_680);
    end
  end

  // Brightness scaling
  assign sc_r = ({8'd0, bri4} + 17'd1) * {9'd0, lvl4.red};
  assign sc_g = ({8'd0, bri4} + 17'd1) * {9'd0, lvl4.green};
  assign sc_b = ({8'd0, bri4} + 17'd1) * {9'd0, lvl4.blue};

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (en) begin
      v1 <= item.valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  // Payload stages
  always_ff @(posedge clk) begin
    if (en) begin
      cmd1       <= item.command;
      rgb1.red   <= item.red;
      rgb1.green <= item.green;
      rgb1.blue  <= item.blue;
      hue1       <= item.hue;
      sat1       <= (item.saturation > 8'(SAT_MAX)) ? 8'(SAT_MAX) : item.saturation;
      bri1       <= item.brightness;

      cmd2  <= cmd1;
      rgb2  <= rgb1;
      hue2  <= hue1;
      sat2  <= sat1;
      bri2  <= bri1;
      quot2 <= quot_prod[32:26];

      cmd3 <= cmd2;
      rgb3 <= rgb2;
      h3   <= rem_fix[9:0];
      sat3 <= sat2;
      bri3 <= bri2;

      cmd4       <= cmd3;
      rgb4       <= rgb3;
      bri4       <= bri3;
      lvl4.red   <= chan_level(sat3, off_r);
      lvl4.green <= chan_level(sat3, off_g);
      lvl4.blue  <= chan_level(sat3, off_b);

      if (cmd4 == CMD_RGB) begin
        out5 <= rgb4;
      end else begin
        out5.red   <= sc_r[15:8];
        out5.green <= sc_g[15:8];
        out5.blue  <= sc_b[15:8];
      end
    end
  end

endmodule

/* rtl/hsbrgb_queue.sv */
// Two-entry colour queue between the front and back parts.
// Register based; uses hsbrgb_pkg.
module hsbrgb_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_valid,
  output logic                  wr_ready,
  input  hsbrgb_pkg::chan_set_t wr_data,
  output logic                  rd_valid,
  input  logic                  rd_ready,
  output hsbrgb_pkg::chan_set_t rd_data
);
  import hsbrgb_pkg::*;

  chan_set_t  entry [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       push, pop;

  assign wr_ready = (count != 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_data  = entry[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  // Store
  always_ff @(posedge clk) begin
    if (push) entry[wr_ptr] <= wr_data;
  end

endmodule

/* rtl/hsbrgb_back.sv */
// Back part: walks a colour's frame slots, one grey-level word per cycle unless stalled.
// Output register on the result channel; uses hsbrgb_pkg and hsbrgb_out_if.
module hsbrgb_back #(
  parameter int LED_COUNT = 8,
  parameter int GRAY_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  hd_valid,
  output logic                  hd_ready,
  input  hsbrgb_pkg::chan_set_t hd_data,
  hsbrgb_out_if.source          result
);
  import hsbrgb_pkg::*;

  localparam int NWORDS     = 3 * LED_COUNT;
  localparam int GRAY_SHIFT = GRAY_BITS - 8;

  logic [SLOT_W-1:0] cnt;
  color_t            col;
  logic              load, at_end;
  logic [7:0]        lvl;
  logic [23:0]       wide;

  logic              o_valid;
  logic [GRAY_W-1:0] o_gray;
  logic [SLOT_W-1:0] o_slot;
  color_t            o_color;
  logic              o_last;

  assign load     = hd_valid && (!o_valid || result.ready);
  assign at_end   = (cnt == SLOT_W'(NWORDS - 1));
  assign hd_ready = load && at_end;

  // Pick the channel for this slot and widen it
  always_comb begin
    case (col)
      COLOR_BLUE:  lvl = hd_data.blue;
      COLOR_GREEN: lvl = hd_data.green;
      COLOR_RED:   lvl = hd_data.red;
      default:     lvl = 8'd0;
    endcase
  end
  assign wide = {16'd0, lvl} << GRAY_SHIFT;

  // Slot and colour counters
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      col <= COLOR_BLUE;
    end else if (load) begin
      if (at_end) begin
        cnt <= '0;
        col <= COLOR_BLUE;
      end else begin
        cnt <= cnt + SLOT_W'(1);
        case (col)
          COLOR_BLUE:  col <= COLOR_GREEN;
          COLOR_GREEN: col <= COLOR_RED;
          default:     col <= COLOR_BLUE;
        endcase
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (load) begin
      o_valid <= 1'b1;
    end else if (result.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      o_gray  <= wide[GRAY_W-1:0];
      o_slot  <= cnt;
      o_color <= col;
      o_last  <= at_end;
    end
  end

  assign result.valid      = o_valid;
  assign result.gray_level = o_gray;
  assign result.slot       = o_slot;
  assign result.color      = o_color;
  assign result.last       = o_last;

endmodule

/* rtl/hsb_to_rgb_led_frame_sender.sv */
// Channel  Dir  Payload                                            Role
// item     in   command, red, green, blue, hue, saturation, bri.   one colour per transfer
// result   out  gray_level, slot, color, last                      3*LED_COUNT words per colour
//
// Each colour gives 3*LED_COUNT words, one per cycle while result is ready, a rate set by the
// single word path of the back part. The front pipe is five stages deep for both commands;
// with nothing queued ahead, the first word is offered once the colour has passed the five
// front stages, the queue write and then the output register.
// Reset (rst, synchronous) clears all valid bits, the queue and the slot counter.
// A stall on result holds the current word; the front keeps taking colours until the queue is
// full and its last stage holds a colour, then the whole front pipe holds.
// Depends on hsbrgb_pkg, hsbrgb_in_if, hsbrgb_out_if, hsbrgb_front, hsbrgb_queue, hsbrgb_back.
module hsb_to_rgb_led_frame_sender #(
  parameter int LED_COUNT = 8,
  parameter int GRAY_BITS = 12
) (
  input  logic         clk,
  input  logic         rst,
  hsbrgb_in_if.sink    item,
  hsbrgb_out_if.source result
);
  import hsbrgb_pkg::*;

  logic      f_valid, f_ready;
  chan_set_t f_data;
  logic      h_valid, h_ready;
  chan_set_t h_data;

  hsbrgb_front u_front (
    .clk     (clk),
    .rst     (rst),
    .item    (item),
    .q_valid (f_valid),
    .q_ready (f_ready),
    .q_data  (f_data)
  );

  hsbrgb_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_data  (f_data),
    .rd_valid (h_valid),
    .rd_ready (h_ready),
    .rd_data  (h_data)
  );

  hsbrgb_back #(
    .LED_COUNT (LED_COUNT),
    .GRAY_BITS (GRAY_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .hd_valid (h_valid),
    .hd_ready (h_ready),
    .hd_data  (h_data),
    .result   (result)
  );

`ifndef NO_ASSERTIONS
  // The frame ends on a red word
  a_last_red: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.last) |-> (result.color == COLOR_RED))
    else $error("last word is not red");

  // A frame starts on a blue word
  a_first_blue: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.slot == '0) |-> (result.color == COLOR_BLUE))
    else $error("slot zero is not blue");

  // Within a frame the next word follows at once with the next slot
  a_slot_step: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.ready && !result.last)
      |=> (result.valid && result.slot == $past(result.slot) + 5'd1))
    else $error("frame word missing or out of order");

  // The queue head is only released on the final word of a frame
  a_pop_last: assert property (@(posedge clk) disable iff (rst)
    (h_valid && h_ready) |=> (result.valid && result.last))
    else $error("colour released before its last word");
`endif

endmodule

/* tb/hsbrgb_frame_checker.sv */
// Frame checker for the HSB to RGB LED frame sender: watches both channels,
// predicts the 24-word frame of every accepted colour and compares each result word.
// Depends on hsbrgb_pkg, hsbrgb_in_if and hsbrgb_out_if.
`timescale 1ns / 100ps

module hsbrgb_frame_checker #(
  parameter int LED_COUNT = 8,
  parameter int GRAY_BITS = 12
) (
  input  logic  clk,
  input  logic  rst,
  hsbrgb_in_if  item,
  hsbrgb_out_if result,
  output int    fail_count,
  output int    words_pending,
  output int    colors_seen,
  output int    hsb_seen,
  output int    words_checked
);
  import hsbrgb_pkg::*;

  localparam int WORDS_PER_FRAME = 3 * LED_COUNT;

  typedef struct packed {
    logic [GRAY_W-1:0] gray_level;
    logic [SLOT_W-1:0] slot;
    color_t            color;
    logic              last;
  } frame_word_t;

  frame_word_t frame_q[$];

  // One channel of the three-sector conversion, then brightness scaling
  function automatic logic [7:0] hsb_level(input int sat, input int off, input int bri);
    int level;
    level = CHAN_BASE - sat * off;
    if (level < 0) level = 0;
    level = (level >>> 7) & 255;
    return 8'(((bri + 1) * level) >> 8);
  endfunction

  // Channel levels of one colour command
  function automatic chan_set_t color_levels(
    input logic        command,
    input logic [7:0]  red,
    input logic [7:0]  green,
    input logic [7:0]  blue,
    input logic [15:0] hue,
    input logic [7:0]  saturation,
    input logic [7:0]  brightness
  );
    chan_set_t lv;
    int h;
    int s;
    int b;
    h = int'(hue) % HUE_MOD;
    s = (int'(saturation) > SAT_MAX) ? SAT_MAX : int'(saturation);
    b = int'(brightness);
    if (command != CMD_HSB) begin
      lv.red   = red;
      lv.green = green;
      lv.blue  = blue;
    end else if (h < SECTOR_1) begin
      lv.red   = hsb_level(s, h - OFS_170, b);
      lv.green = hsb_level(s, OFS_85 - h, b);
      lv.blue  = hsb_level(s, OFS_85, b);
    end else if (h < SECTOR_2) begin
      lv.red   = hsb_level(s, OFS_85, b);
      lv.green = hsb_level(s, h - OFS_425, b);
      lv.blue  = hsb_level(s, OFS_340 - h, b);
    end else begin
      lv.red   = hsb_level(s, OFS_595 - h, b);
      lv.green = hsb_level(s, OFS_85, b);
      lv.blue  = hsb_level(s, h - OFS_680, b);
    end
    return lv;
  endfunction

  // Queue the whole frame of one colour: blue, green, red per LED
  task automatic queue_frame(input chan_set_t lv);
    frame_word_t w;
    logic [7:0]  level;
    for (int k = 0; k < WORDS_PER_FRAME; k++) begin
      w.color = color_t'(k % 3);
      case (w.color)
        COLOR_BLUE:  level = lv.blue;
        COLOR_GREEN: level = lv.green;
        default:     level = lv.red;
      endcase
      w.gray_level = GRAY_W'({level, 8'h00} >> (16 - GRAY_BITS));
      w.slot       = SLOT_W'(k);
      w.last       = (k == WORDS_PER_FRAME - 1);
      frame_q.push_back(w);
    end
  endtask

  // Compare result transfers first, then queue the frame of a new colour
  always @(posedge clk) begin
    frame_word_t want;
    frame_word_t got;
    if (!rst) begin
      if (result.valid && result.ready) begin
        got = '{result.gray_level, result.slot, color_t'(result.color), result.last};
        if (frame_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected word gray=%h slot=%0d color=%0d last=%b",
                   $time, got.gray_level, got.slot, got.color, got.last);
        end else begin
          want = frame_q.pop_front();
          words_checked++;
          if (got.gray_level !== want.gray_level || got.slot !== want.slot ||
              got.color !== want.color || got.last !== want.last) begin
            fail_count++;
            $display("%0t: word mismatch expected gray=%h slot=%0d color=%0d last=%b",
                     $time, want.gray_level, want.slot, want.color, want.last);
            $display("%0t:                 actual gray=%h slot=%0d color=%0d last=%b",
                     $time, got.gray_level, got.slot, got.color, got.last);
          end
        end
      end
      if (item.valid && item.ready) begin
        colors_seen++;
        if (item.command == CMD_HSB) hsb_seen++;
        queue_frame(color_levels(item.command, item.red, item.green, item.blue,
                                 item.hue, item.saturation, item.brightness));
      end
    end
    words_pending = frame_q.size();
  end

endmodule

/* tb/tb_hsb_to_rgb_led_frame_sender.sv */
// Testbench top for the HSB to RGB LED frame sender: drives colour commands with random
// gaps, stalls the result channel and reports the verdict from the frame checker.
// Depends on hsbrgb_pkg, both channel interfaces, the block and hsbrgb_frame_checker.
`timescale 1ns / 100ps

module tb_hsb_to_rgb_led_frame_sender;
  import hsbrgb_pkg::*;

  localparam int RANDOM_COLORS  = 450;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 40;

  logic clk;
  logic rst;
  bit   no_stall;
  int   idle_cycles;
  int   fail_count;
  int   words_pending;
  int   colors_seen;
  int   hsb_seen;
  int   words_checked;

  hsbrgb_in_if  item_if ();
  hsbrgb_out_if result_if ();

  hsb_to_rgb_led_frame_sender u_top (
    .clk    (clk),
    .rst    (rst),
    .item   (item_if),
    .result (result_if)
  );

  hsbrgb_frame_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .item          (item_if),
    .result        (result_if),
    .fail_count    (fail_count),
    .words_pending (words_pending),
    .colors_seen   (colors_seen),
    .hsb_seen      (hsb_seen),
    .words_checked (words_checked)
  );

  // 10 ns clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Gap length: mostly none or short, a few long
  function automatic int pick_gap();
    int r;
    if (no_stall) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Present one colour and hold it until the transfer
  task automatic send_color(input logic cmd, input logic [7:0] r, input logic [7:0] g,
                            input logic [7:0] b, input logic [15:0] h,
                            input logic [7:0] s, input logic [7:0] br);
    @(negedge clk);
    item_if.valid      <= 1'b1;
    item_if.command    <= cmd;
    item_if.red        <= r;
    item_if.green      <= g;
    item_if.blue       <= b;
    item_if.hue        <= h;
    item_if.saturation <= s;
    item_if.brightness <= br;
    do @(posedge clk); while (!(item_if.valid && item_if.ready));
  endtask

  // Drop valid for a number of cycles
  task automatic hold_off(input int gap);
    if (gap > 0) begin
      @(negedge clk);
      item_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // HSB colour with random, ignored RGB fields
  task automatic drive_hsb(input logic [15:0] h, input logic [7:0] s, input logic [7:0] br);
    send_color(CMD_HSB, 8'($urandom), 8'($urandom), 8'($urandom), h, s, br);
    hold_off(pick_gap());
  endtask

  // RGB colour with random, ignored HSB fields
  task automatic drive_rgb(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    send_color(CMD_RGB, r, g, b, 16'($urandom), 8'($urandom), 8'($urandom));
    hold_off(pick_gap());
  endtask

  // Random hue: mostly in range, some wrapped, some on sector bounds
  function automatic logic [15:0] pick_hue();
    int r;
    int unsigned bounds[8] = '{0, 254, 255, 509, 510, 764, 765, 65535};
    r = $urandom_range(0, 99);
    if (r < 50) return 16'($urandom_range(0, HUE_MOD - 1));
    if (r < 80) return 16'($urandom);
    return 16'(bounds[$urandom_range(0, 7)]);
  endfunction

  // Result-side stalls
  initial begin
    int run;
    int gap;
    result_if.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      run = $urandom_range(1, 30);
      @(negedge clk);
      result_if.ready <= 1'b1;
      repeat (run - 1) @(negedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        @(negedge clk);
        result_if.ready <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (item_if.valid && item_if.ready) || (result_if.valid && result_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("%0t: no transfer for %0d cycles, %0d words outstanding",
                 $time, WATCHDOG_LIMIT, words_pending);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Stimulus and verdict
  initial begin
    no_stall           = 1'b0;
    rst                = 1'b1;
    item_if.valid      = 1'b0;
    item_if.command    = CMD_RGB;
    item_if.red        = '0;
    item_if.green      = '0;
    item_if.blue       = '0;
    item_if.hue        = '0;
    item_if.saturation = '0;
    item_if.brightness = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: RGB extremes and bit patterns
    drive_rgb(8'h00, 8'h00, 8'h00);
    drive_rgb(8'hFF, 8'hFF, 8'hFF);
    drive_rgb(8'hFF, 8'h00, 8'h00);
    drive_rgb(8'h00, 8'hFF, 8'h00);
    drive_rgb(8'h00, 8'h00, 8'hFF);
    drive_rgb(8'hAA, 8'h55, 8'hA5);
    // Directed: sector bounds, hue wrap, saturation clamp, brightness extremes
    drive_hsb(16'd0,     8'd128, 8'd255);
    drive_hsb(16'd254,   8'd128, 8'd255);
    drive_hsb(16'd255,   8'd128, 8'd255);
    drive_hsb(16'd509,   8'd128, 8'd255);
    drive_hsb(16'd510,   8'd128, 8'd255);
    drive_hsb(16'd764,   8'd128, 8'd255);
    drive_hsb(16'd765,   8'd100, 8'd200);
    drive_hsb(16'd65535, 8'd64,  8'd255);
    drive_hsb(16'd300,   8'd0,   8'd255);
    drive_hsb(16'd600,   8'd129, 8'd255);
    drive_hsb(16'd100,   8'd255, 8'd0);
    drive_hsb(16'd400,   8'd127, 8'd1);
    drive_hsb(16'hAAAA,  8'hAA,  8'h55);
    drive_hsb(16'h5555,  8'h55,  8'hAA);

    // Random colours; one run without idling and one full drain
    for (int i = 0; i < RANDOM_COLORS; i++) begin
      no_stall = (i >= 100 && i < 160);
      if (i == 250) begin
        hold_off(1);
        @(negedge clk);
        while (words_pending != 0) @(negedge clk);
      end
      if ($urandom_range(0, 1)) begin
        drive_hsb(pick_hue(),
                  ($urandom_range(0, 9) < 6) ? 8'($urandom_range(0, SAT_MAX)) : 8'($urandom),
                  8'($urandom));
      end else begin
        drive_rgb(8'($urandom), 8'($urandom), 8'($urandom));
      end
    end
    no_stall = 1'b0;
    hold_off(1);

    // Drain and let any stray word show up
    @(negedge clk);
    while (words_pending != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Sent %0d colours (%0d HSB, %0d RGB) and checked %0d frame words.",
             colors_seen, hsb_seen, colors_seen - hsb_seen, words_checked);
    $display("Mismatches and unexpected words: %0d", fail_count);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
